>>> sv/scf_pkg.sv
// Shared types and constants of the servo command frame builder.
package scf_pkg;

	typedef enum logic [2:0] {
		KIND_ASSIGN     = 3'd0,
		KIND_PLAIN      = 3'd1,
		KIND_RAW        = 3'd2,
		KIND_LONG_SHORT = 3'd3,
		KIND_RGB        = 3'd4,
		KIND_SHORT3     = 3'd5,
		KIND_RAW_SPEED  = 3'd6
	} kind_t;

	localparam int unsigned BODY_MAX = 11;
	localparam int unsigned BODY_IDX_W = 4;
	localparam int unsigned CFG_ADDR_W = 4;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [1:0] REG_START_BYTE    = 2'd0;
	localparam logic [1:0] REG_END_BYTE      = 2'd1;
	localparam logic [1:0] REG_BROADCAST_ID  = 2'd2;
	localparam logic [1:0] REG_MAX_DEVICE_ID = 2'd3;

	localparam logic [7:0] START_BYTE_RST    = 8'hF0;
	localparam logic [7:0] END_BYTE_RST      = 8'hF7;
	localparam logic [7:0] BROADCAST_ID_RST  = 8'hFF;
	localparam logic [7:0] MAX_DEVICE_ID_RST = 8'h00;

	localparam logic [7:0] ASSIGN_ZERO = 8'h00;
	localparam logic [7:0] ASSIGN_TAIL = 8'h0F;
	localparam logic [7:0] REJECT_BYTE = 8'h00;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] broadcast_id;
		logic [7:0] max_device_id;
	} cfg_t;

	typedef struct packed {
		logic                        rejected;
		logic                        has_sum;
		logic [BODY_IDX_W-1:0]       n_body;
		logic [BODY_MAX-1:0][7:0]    body;
	} desc_t;

endpackage

>>> sv/scf_if.sv
// Request and response channel interfaces of the servo command frame builder.
interface scf_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [7:0]         dev_id;
	logic [6:0]         service;
	logic [6:0]         command;
	logic [7:0]         raw_byte;
	logic signed [31:0] long_value;
	logic signed [15:0] short_value;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;

	modport source (
		output valid, kind, dev_id, service, command, raw_byte,
		output long_value, short_value, red, green, blue,
		input ready
	);
	modport sink (
		input valid, kind, dev_id, service, command, raw_byte,
		input long_value, short_value, red, green, blue,
		output ready
	);
endinterface

interface scf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last;
	logic       rejected;

	modport source (output valid, tx_byte, last, rejected, input ready);
	modport sink (input valid, tx_byte, last, rejected, output ready);
endinterface

>>> sv/scf_front.sv
// Front stage: accepts a request and classifies it into a frame descriptor.
module scf_front (
	scf_req_if.sink        req,
	input  scf_pkg::cfg_t  cfg,
	input  logic           queue_full,
	output logic           push,
	output scf_pkg::desc_t desc
);
	import scf_pkg::*;

	kind_t       kind;
	logic [15:0] sval;
	logic [15:0] mag;
	logic [31:0] lval;
	logic        out_of_range;

	assign req.ready = !queue_full;
	assign push = req.valid && !queue_full;

	always_comb begin
		kind = kind_t'(req.kind);
		sval = req.short_value;
		lval = req.long_value;
		mag = sval[15] ? (~sval + 16'd1) : sval;
		out_of_range = (req.dev_id > cfg.max_device_id) && (req.dev_id != cfg.broadcast_id);

		desc = '0;
		desc.has_sum = 1'b1;
		desc.body[0] = cfg.start_byte;
		desc.body[1] = req.dev_id;
		desc.body[2] = {1'b0, req.service};
		desc.body[3] = {1'b0, req.command};

		case (kind)
			KIND_ASSIGN: begin
				desc.has_sum = 1'b0;
				desc.body[3] = ASSIGN_ZERO;
				desc.body[4] = ASSIGN_TAIL;
				desc.n_body = BODY_IDX_W'(5);
			end
			KIND_PLAIN: begin
				desc.n_body = BODY_IDX_W'(4);
			end
			KIND_RAW: begin
				desc.body[4] = req.raw_byte;
				desc.n_body = BODY_IDX_W'(5);
			end
			KIND_LONG_SHORT: begin
				desc.body[4] = {1'b0, lval[6:0]};
				desc.body[5] = {1'b0, lval[13:7]};
				desc.body[6] = {1'b0, lval[20:14]};
				desc.body[7] = {1'b0, lval[27:21]};
				desc.body[8] = {4'b0, lval[31:28]};
				desc.body[9] = {1'b0, sval[6:0]};
				desc.body[10] = {1'b0, sval[13:7]};
				desc.n_body = BODY_IDX_W'(11);
			end
			KIND_RGB: begin
				desc.body[4] = {1'b0, req.red[6:0]};
				desc.body[5] = {7'b0, req.red[7]};
				desc.body[6] = {1'b0, req.green[6:0]};
				desc.body[7] = {7'b0, req.green[7]};
				desc.body[8] = {1'b0, req.blue[6:0]};
				desc.body[9] = {7'b0, req.blue[7]};
				desc.n_body = BODY_IDX_W'(10);
			end
			KIND_SHORT3: begin
				desc.body[4] = {1'b0, sval[6:0]};
				desc.body[5] = {1'b0, sval[13:7]};
				desc.body[6] = {6'b0, sval[15:14]};
				desc.n_body = BODY_IDX_W'(7);
			end
			KIND_RAW_SPEED: begin
				desc.body[4] = req.raw_byte;
				desc.body[5] = {1'b0, mag[6:0]};
				desc.body[6] = {1'b0, mag[13:7]};
				desc.n_body = BODY_IDX_W'(7);
			end
			default: begin
				desc.rejected = 1'b1;
			end
		endcase

		if (kind != KIND_ASSIGN && out_of_range) begin
			desc.rejected = 1'b1;
		end
	end
endmodule

>>> sv/scf_queue.sv
// Small descriptor queue between the front and back stages.
module scf_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  scf_pkg::desc_t wr_desc,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output scf_pkg::desc_t rd_desc
);
	import scf_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	desc_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_desc = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end
endmodule

>>> sv/scf_back.sv
// Back stage: walks a descriptor plus checksum, one byte per cycle while rsp.ready.
module scf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  scf_pkg::cfg_t  cfg,
	input  logic           head_valid,
	input  scf_pkg::desc_t head,
	output logic           pop,
	scf_rsp_if.source      rsp
);
	import scf_pkg::*;

	logic [BODY_IDX_W-1:0] idx_q;
	logic [6:0]            sum_q;
	logic                  out_valid_q;
	logic [7:0]            tx_byte_q;
	logic                  last_q;
	logic                  rejected_q;

	logic                  load;
	logic [7:0]            cur_byte;
	logic                  cur_last;
	logic                  in_body;

	assign rsp.valid = out_valid_q;
	assign rsp.tx_byte = tx_byte_q;
	assign rsp.last = last_q;
	assign rsp.rejected = rejected_q;

	assign load = head_valid && (!out_valid_q || rsp.ready);
	assign pop = load && cur_last;
	assign in_body = (idx_q < head.n_body);

	always_comb begin
		cur_byte = cfg.end_byte;
		cur_last = 1'b1;
		if (head.rejected) begin
			cur_byte = REJECT_BYTE;
		end else if (in_body) begin
			cur_byte = head.body[idx_q];
			cur_last = 1'b0;
		end else if (head.has_sum && idx_q == head.n_body) begin
			cur_byte = {1'b0, sum_q};
			cur_last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (cur_last) begin
					idx_q <= '0;
					sum_q <= '0;
				end else begin
					idx_q <= idx_q + BODY_IDX_W'(1);
					if (head.has_sum && in_body && idx_q != '0) begin
						sum_q <= sum_q + cur_byte[6:0];
					end
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_byte_q <= cur_byte;
			last_q <= cur_last;
			rejected_q <= head.rejected;
		end
	end
endmodule

>>> sv/servo_command_frame_builder.sv
// Servo command frame builder: turns each request into its serial frame, one byte per
// response, with last set on the closing byte. A frame has 1 byte for a rejected request
// and 6 to 13 bytes otherwise; the back stage emits one byte per cycle into its output
// register while the response side is ready. Up to QUEUE_DEPTH classified requests wait
// in the queue, so the front accepts the next request while a frame is still being sent.
// Registers at byte addresses 0, 4, 8, 12: start byte, end byte, broadcast id, maximum id.
module servo_command_frame_builder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	scf_req_if.sink                        req,
	scf_rsp_if.source                      rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [scf_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [scf_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [scf_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);
	import scf_pkg::*;

	cfg_t  cfg_q;
	desc_t wr_desc;
	desc_t rd_desc;
	logic  push;
	logic  pop;
	logic  full;
	logic  not_empty;
	logic  cfg_write;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_BYTE_RST;
			cfg_q.end_byte <= END_BYTE_RST;
			cfg_q.broadcast_id <= BROADCAST_ID_RST;
			cfg_q.max_device_id <= MAX_DEVICE_ID_RST;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_START_BYTE:    cfg_q.start_byte <= pwdata[7:0];
				REG_END_BYTE:      cfg_q.end_byte <= pwdata[7:0];
				REG_BROADCAST_ID:  cfg_q.broadcast_id <= pwdata[7:0];
				REG_MAX_DEVICE_ID: cfg_q.max_device_id <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_START_BYTE:    prdata = CFG_DATA_W'(cfg_q.start_byte);
			REG_END_BYTE:      prdata = CFG_DATA_W'(cfg_q.end_byte);
			REG_BROADCAST_ID:  prdata = CFG_DATA_W'(cfg_q.broadcast_id);
			REG_MAX_DEVICE_ID: prdata = CFG_DATA_W'(cfg_q.max_device_id);
			default:           prdata = '0;
		endcase
	end

	scf_front u_front (
		.req        (req),
		.cfg        (cfg_q),
		.queue_full (full),
		.push       (push),
		.desc       (wr_desc)
	);

	scf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_desc   (wr_desc),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.rd_desc   (rd_desc)
	);

	scf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (not_empty),
		.head       (rd_desc),
		.pop        (pop),
		.rsp        (rsp)
	);
endmodule

>>> sv/scf_checker.sv
// Port-level assertions for the servo command frame builder and their bind.
module scf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_tx_byte,
	input logic       rsp_last,
	input logic       rsp_rejected
);
	import scf_pkg::*;

	a_reject_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_rejected |-> rsp_last)
		else $error("Rejected response is not marked last.");

	a_reject_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_rejected |-> rsp_tx_byte == REJECT_BYTE)
		else $error("Rejected response carries a nonzero byte.");

	a_reject_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_last |=> !(rsp_valid && rsp_rejected))
		else $error("Rejected response appears inside a frame.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last))
		else $error("Stalled response changed.");
endmodule

bind servo_command_frame_builder scf_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_tx_byte  (rsp.tx_byte),
	.rsp_last     (rsp.last),
	.rsp_rejected (rsp.rejected)
);

>>> test/tb_servo_command_frame_builder.sv
// Testbench for the servo command frame builder: predicts every frame byte and checks each response.
`timescale 1ns / 1ps

module tb_servo_command_frame_builder;
	import scf_pkg::*;

	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned ITEMS_PER_SETTING = 40;
	localparam logic [2:0] KIND_UNKNOWN = 3'd7;

	typedef struct {
		logic [2:0]         kind;
		logic [7:0]         dev_id;
		logic [6:0]         service;
		logic [6:0]         command;
		logic [7:0]         raw_byte;
		logic signed [31:0] long_value;
		logic signed [15:0] short_value;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} cmd_t;

	typedef struct {
		logic [7:0] tx_byte;
		logic       last;
		logic       rejected;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	scf_req_if req_ch ();
	scf_rsp_if rsp_ch ();

	servo_command_frame_builder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	frame_byte_t expected_bytes[$];
	frame_byte_t got_byte;
	cfg_t cfg;
	int unsigned errors = 0;
	int unsigned n_cmds = 0;
	int unsigned n_rejects = 0;
	int unsigned n_bytes = 0;
	int unsigned n_settings = 1;
	bit no_idle = 1'b0;
	bit hold_rsp = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [7:0] septet(input logic [31:0] v, input int idx);
		return {1'b0, 7'(v >> (7 * idx))};
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic is_last, input logic rej);
		frame_byte_t e;
		e.tx_byte = b;
		e.last = is_last;
		e.rejected = rej;
		expected_bytes.push_back(e);
	endfunction

	function automatic void predict_frame(input cmd_t c);
		logic [7:0] body[$];
		logic [6:0] sum;
		logic [15:0] speed;
		sum = '0;
		speed = c.short_value;
		if (c.kind == KIND_ASSIGN) begin
			push_byte(cfg.start_byte, 1'b0, 1'b0);
			push_byte(c.dev_id, 1'b0, 1'b0);
			push_byte({1'b0, c.service}, 1'b0, 1'b0);
			push_byte(ASSIGN_ZERO, 1'b0, 1'b0);
			push_byte(ASSIGN_TAIL, 1'b0, 1'b0);
			push_byte(cfg.end_byte, 1'b1, 1'b0);
			return;
		end
		if (c.kind > KIND_RAW_SPEED ||
				(c.dev_id > cfg.max_device_id && c.dev_id != cfg.broadcast_id)) begin
			push_byte(REJECT_BYTE, 1'b1, 1'b1);
			n_rejects++;
			return;
		end
		body = '{c.dev_id, {1'b0, c.service}, {1'b0, c.command}};
		case (c.kind)
			KIND_RAW: body.push_back(c.raw_byte);
			KIND_LONG_SHORT: begin
				for (int i = 0; i < 5; i++) body.push_back(septet(c.long_value, i));
				for (int i = 0; i < 2; i++) body.push_back(septet({16'b0, speed}, i));
			end
			KIND_RGB: begin
				for (int i = 0; i < 2; i++) body.push_back(septet({24'b0, c.red}, i));
				for (int i = 0; i < 2; i++) body.push_back(septet({24'b0, c.green}, i));
				for (int i = 0; i < 2; i++) body.push_back(septet({24'b0, c.blue}, i));
			end
			KIND_SHORT3: begin
				for (int i = 0; i < 3; i++) body.push_back(septet({16'b0, speed}, i));
			end
			KIND_RAW_SPEED: begin
				body.push_back(c.raw_byte);
				if (speed[15]) speed = -speed;
				for (int i = 0; i < 2; i++) body.push_back(septet({16'b0, speed}, i));
			end
			default: ;
		endcase
		push_byte(cfg.start_byte, 1'b0, 1'b0);
		foreach (body[i]) begin
			push_byte(body[i], 1'b0, 1'b0);
			sum = sum + body[i][6:0];
		end
		push_byte({1'b0, sum}, 1'b0, 1'b0);
		push_byte(cfg.end_byte, 1'b1, 1'b0);
	endfunction

	function automatic cmd_t make_cmd(input logic [2:0] kind, input logic [7:0] dev,
			input logic [6:0] svc, input logic [6:0] cmd, input logic [7:0] raw,
			input logic [31:0] lv, input logic [15:0] sv, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		cmd_t c;
		c.kind = kind;
		c.dev_id = dev;
		c.service = svc;
		c.command = cmd;
		c.raw_byte = raw;
		c.long_value = lv;
		c.short_value = sv;
		c.red = r;
		c.green = g;
		c.blue = b;
		return c;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		c.kind = 3'($urandom_range(0, 7));
		if (pick < 6) c.dev_id = 8'($urandom_range(0, cfg.max_device_id));
		else if (pick < 8) c.dev_id = cfg.broadcast_id;
		else c.dev_id = 8'($urandom);
		c.service = 7'($urandom);
		c.command = 7'($urandom);
		c.raw_byte = 8'($urandom);
		c.long_value = $urandom;
		c.short_value = 16'($urandom);
		c.red = 8'($urandom);
		c.green = 8'($urandom);
		c.blue = 8'($urandom);
		return c;
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_cmd(input cmd_t c);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= c.kind;
		req_ch.dev_id <= c.dev_id;
		req_ch.service <= c.service;
		req_ch.command <= c.command;
		req_ch.raw_byte <= c.raw_byte;
		req_ch.long_value <= c.long_value;
		req_ch.short_value <= c.short_value;
		req_ch.red <= c.red;
		req_ch.green <= c.green;
		req_ch.blue <= c.blue;
		do @(posedge clk); while (!req_ch.ready);
		predict_frame(c);
		n_cmds++;
		@(negedge clk);
	endtask

	task automatic wait_frames_done();
		req_ch.valid <= 1'b0;
		while (expected_bytes.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'b0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_START_BYTE: cfg.start_byte = value;
			REG_END_BYTE: cfg.end_byte = value;
			REG_BROADCAST_ID: cfg.broadcast_id = value;
			REG_MAX_DEVICE_ID: cfg.max_device_id = value;
			default: ;
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== value) begin
			$display("%0t ERROR: register %0d read expected %h actual %h",
				$realtime, idx, value, prdata[7:0]);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_apply(input logic [7:0] sb, input logic [7:0] eb,
			input logic [7:0] bc, input logic [7:0] mx);
		wait_frames_done();
		cfg_write(REG_START_BYTE, sb);
		cfg_write(REG_END_BYTE, eb);
		cfg_write(REG_BROADCAST_ID, bc);
		cfg_write(REG_MAX_DEVICE_ID, mx);
		n_settings++;
	endtask

	task automatic test_frame_kinds();
		send_cmd(make_cmd(KIND_ASSIGN, 8'hFF, 7'h7F, 7'h7F, 8'h00, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_PLAIN, 8'h00, 7'h00, 7'h7F, 8'hFF, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_RAW, 8'h00, 7'h7F, 7'h00, 8'hFF, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_RAW, 8'hFF, 7'h2A, 7'h55, 8'h00, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_LONG_SHORT, 8'h00, 7'h11, 7'h22, 8'h00,
			32'h8000_0000, 16'h7FFF, 0, 0, 0));
		send_cmd(make_cmd(KIND_LONG_SHORT, 8'hFF, 7'h7F, 7'h7F, 8'h00,
			32'h7FFF_FFFF, 16'h8000, 0, 0, 0));
		send_cmd(make_cmd(KIND_LONG_SHORT, 8'h00, 7'h01, 7'h02, 8'h00,
			32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0));
		send_cmd(make_cmd(KIND_RGB, 8'h00, 7'h7F, 7'h7F, 8'h00, 0, 0, 8'hFF, 8'hFF, 8'hFF));
		send_cmd(make_cmd(KIND_RGB, 8'hFF, 7'h00, 7'h00, 8'h00, 0, 0, 8'h00, 8'h80, 8'h7F));
		send_cmd(make_cmd(KIND_SHORT3, 8'h00, 7'h33, 7'h44, 8'h00, 0, 16'hFFFF, 0, 0, 0));
		send_cmd(make_cmd(KIND_SHORT3, 8'h00, 7'h33, 7'h44, 8'h00, 0, 16'h8000, 0, 0, 0));
		send_cmd(make_cmd(KIND_RAW_SPEED, 8'h00, 7'h05, 7'h06, 8'hFF, 0, 16'h8000, 0, 0, 0));
		send_cmd(make_cmd(KIND_RAW_SPEED, 8'hFF, 7'h05, 7'h06, 8'h80, 0, 16'hFFFF, 0, 0, 0));
		send_cmd(make_cmd(KIND_RAW_SPEED, 8'h00, 7'h05, 7'h06, 8'h00, 0, 16'h7FFF, 0, 0, 0));
	endtask

	task automatic test_id_check();
		send_cmd(make_cmd(KIND_PLAIN, 8'h01, 7'h10, 7'h20, 8'h00, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_UNKNOWN, 8'h00, 7'h10, 7'h20, 8'h00, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_ASSIGN, 8'h55, 7'h10, 7'h20, 8'h00, 0, 0, 0, 0, 0));
		cfg_apply(START_BYTE_RST, END_BYTE_RST, 8'h00, 8'h10);
		send_cmd(make_cmd(KIND_PLAIN, 8'h10, 7'h10, 7'h20, 8'h00, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_RAW, 8'h11, 7'h10, 7'h20, 8'h00, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_PLAIN, 8'h00, 7'h10, 7'h20, 8'h00, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(KIND_RGB, 8'hFF, 7'h10, 7'h20, 8'h00, 0, 0, 1, 2, 3));
	endtask

	task automatic test_output_stall();
		cfg_apply(8'h00, 8'hFF, 8'hFF, 8'hFF);
		hold_rsp = 1'b1;
		no_idle = 1'b1;
		repeat (10) send_cmd(rand_cmd());
		no_idle = 1'b0;
	endtask

	task automatic test_sender_pause();
		repeat (4) send_cmd(rand_cmd());
		wait_frames_done();
		repeat (4) send_cmd(rand_cmd());
	endtask

	task automatic test_random_traffic();
		for (int s = 0; s < 4; s++) begin
			case (s)
				0: cfg_apply(8'hFF, 8'h00, 8'h00, 8'h7F);
				1: cfg_apply(8'hF0, 8'hF7, 8'h80, 8'h00);
				2: cfg_apply(8'h00, 8'hFF, 8'hFF, 8'hFF);
				default: cfg_apply(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
				no_idle = (i >= 20 && i < 30);
				send_cmd(rand_cmd());
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin : rsp_sink
		int unsigned gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rsp = 1'b0;
			end else begin
				gap = no_idle ? 0 : $urandom_range(0, 8);
				if (gap > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid || hold_rsp));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t ERROR: unexpected byte, expected none actual tx=%h last=%b rej=%b",
					$realtime, rsp_ch.tx_byte, rsp_ch.last, rsp_ch.rejected);
				errors++;
			end else begin
				got_byte = expected_bytes.pop_front();
				n_bytes++;
				if (rsp_ch.tx_byte !== got_byte.tx_byte || rsp_ch.last !== got_byte.last ||
						rsp_ch.rejected !== got_byte.rejected) begin
					$display("%0t ERROR: expected tx=%h last=%b rej=%b actual tx=%h last=%b rej=%b",
						$realtime, got_byte.tx_byte, got_byte.last, got_byte.rejected,
						rsp_ch.tx_byte, rsp_ch.last, rsp_ch.rejected);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = '0;
		req_ch.dev_id = '0;
		req_ch.service = '0;
		req_ch.command = '0;
		req_ch.raw_byte = '0;
		req_ch.long_value = '0;
		req_ch.short_value = '0;
		req_ch.red = '0;
		req_ch.green = '0;
		req_ch.blue = '0;
		cfg.start_byte = START_BYTE_RST;
		cfg.end_byte = END_BYTE_RST;
		cfg.broadcast_id = BROADCAST_ID_RST;
		cfg.max_device_id = MAX_DEVICE_ID_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_frame_kinds();
		test_id_check();
		test_output_stall();
		test_sender_pause();
		test_random_traffic();
		wait_frames_done();
		$display("Sent %0d requests (%0d refused) under %0d register settings,", n_cmds,
			n_rejects, n_settings);
		$display("and checked %0d frame bytes including a long output stall.", n_bytes);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
